@@ src/script_source_lexer_assert.svh @@
// Assertion macros used by the lexer back end
`ifndef SCRIPT_SOURCE_LEXER_ASSERT_SVH
`define SCRIPT_SOURCE_LEXER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SSL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SSL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ src/ssl_pkg.sv @@
// Package: token kinds, operator codes, lexer modes and keyword table
`default_nettype none
package ssl_pkg;
  localparam logic [5:0] K_END = 6'd0, K_SINGLE = 6'd1, K_INC = 6'd2, K_DEC = 6'd3,
    K_ASSIGN = 6'd4, K_ARROW = 6'd5, K_MUL = 6'd6, K_OROP = 6'd7, K_ANDOP = 6'd8,
    K_BITOR = 6'd9, K_BITAND = 6'd10, K_EQ = 6'd11, K_REL = 6'd12, K_SHIFT = 6'd13,
    K_NOT = 6'd14, K_BITNOT = 6'd15, K_STRING = 6'd16, K_VAR = 6'd17, K_INT = 6'd18,
    K_BOOL = 6'd19, K_WORD = 6'd20, K_KW0 = 6'd21, K_TEXT = 6'd35, K_ERR = 6'd36;
  localparam logic [4:0] OP_NONE = 5'd0, OP_INC = 5'd1, OP_DEC = 5'd2, OP_ADD = 5'd3,
    OP_SUB = 5'd4, OP_MUL = 5'd5, OP_DIV = 5'd6, OP_MOD = 5'd7, OP_XOR = 5'd8,
    OP_OR = 5'd9, OP_AND = 5'd10, OP_BOR = 5'd11, OP_BAND = 5'd12, OP_SHL = 5'd13,
    OP_SHR = 5'd14, OP_LT = 5'd15, OP_LE = 5'd16, OP_GT = 5'd17, OP_GE = 5'd18,
    OP_NOT = 5'd19, OP_BNOT = 5'd20, OP_NE = 5'd21;
  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;
  localparam logic [30:0] ERR_DIGIT_ALPHA = 31'd1;
  localparam logic [30:0] ERR_OPEN_STRING = 31'd2;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef enum logic [3:0] {
    M_IDLE, M_OP1, M_OP2, M_WORD, M_VAR, M_STR, M_INT, M_COMMENT, M_DEAD
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [4:0]  op;
    logic [30:0] value;
    logic        last;
  } token_t;

  // one queued entry: up to two tokens caused by one byte
  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } entry_t;

  // keyword lengths
  function automatic logic [3:0] kw_len(input logic [3:0] k);
    begin
      unique case (k)
        4'd0, 4'd5: kw_len = 4'd2;
        4'd1, 4'd2, 4'd3, 4'd9, 4'd12: kw_len = 4'd3;
        4'd4: kw_len = 4'd7;
        4'd6, 4'd13, 4'd15: kw_len = 4'd5;
        4'd7, 4'd10, 4'd14: kw_len = 4'd4;
        4'd8: kw_len = 4'd6;
        default: kw_len = 4'd8;
      endcase
    end
  endfunction

  // keyword table: byte at position p of keyword k
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [63:0] w;
    begin
      unique case (k)
        4'd0: w = "my";       4'd1: w = "our";      4'd2: w = "has";
        4'd3: w = "sub";      4'd4: w = "package";  4'd5: w = "if";
        4'd6: w = "elsif";    4'd7: w = "else";     4'd8: w = "return";
        4'd9: w = "for";      4'd10: w = "last";    4'd11: w = "continue";
        4'd12: w = "use";     4'd13: w = "while";   4'd14: w = "true";
        default: w = "false";
      endcase
      kw_char = (p < kw_len(k)) ? w[8*(kw_len(k)-p-1) +: 8] : 8'd0;
    end
  endfunction
endpackage
`default_nettype wire

@@ src/script_source_lexer.sv @@
// Top level: byte-stream tokenizer, front lexer feeding a token queue
// A token caused by a byte is written into the token queue and offered from its head.
// Throughput: one byte per cycle while the result side keeps up; a byte giving two
//   tokens sends them on the result port one after the other, so the four-entry queue may fill.
// Reset (rst_n low, synchronous) returns the lexer to idle and empties the queue.
`default_nettype none
module script_source_lexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_token_kind,
  output logic [4:0]       out_op_code,
  output logic [30:0]      out_value,
  output logic             out_last
);
  ssl_pkg::entry_t ent;
  ssl_pkg::token_t tok;
  logic ent_vld, full, fire;

  assign in_stall = full;
  assign fire = in_valid && !full;

  ssl_front u_front (.clk, .rst_n, .fire, .char_code(in_char_code), .ent, .ent_vld);
  ssl_back u_back (.clk, .rst_n, .push(ent_vld), .ent, .full, .out_valid, .out_stall,
                   .out_tok(tok));

  assign out_token_kind = tok.kind;
  assign out_op_code = tok.op;
  assign out_value = tok.value;
  assign out_last = tok.last;
endmodule
`default_nettype wire

@@ src/ssl_front.sv @@
// Front end: per-byte lexer state machine producing at most one queue entry per byte
`default_nettype none
module ssl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic [7:0]    char_code,
  output ssl_pkg::entry_t    ent,
  output logic               ent_vld
);
  ssl_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] cand_r, cand_nxt;
  logic [3:0]  wlen_r, wlen_nxt;
  logic [30:0] acc_r, acc_nxt;

  logic [7:0] c;
  logic is_dig, is_alp, is_wch, is_blank;
  ssl_pkg::token_t tk [0:1];
  logic [1:0] n;
  // begin() result
  ssl_pkg::mode_t b_mode;
  logic b_emit, b_setpend, b_word, b_int;
  ssl_pkg::token_t b_tk;
  // resolve() result
  logic [1:0] r_code;
  ssl_pkg::token_t r_tk;
  // word feed
  logic [15:0] fed_cand, fresh_cand;
  logic [3:0]  fed_len;
  ssl_pkg::token_t wc_tk;
  logic [34:0] acc10;
  logic [3:0]  dig;

  assign c = char_code;
  assign is_dig = c >= "0" && c <= "9";
  assign is_alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_wch = is_dig || is_alp || c == "_" || c == ":";
  assign is_blank = c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd255;
  assign dig = c[3:0] - 4'd0;

  function automatic ssl_pkg::token_t mk(input logic [5:0] k, input logic [4:0] o,
                                         input logic [30:0] v);
    ssl_pkg::token_t t;
    begin
      t.kind = k; t.op = o; t.value = v; t.last = 1'b0;
      mk = t;
    end
  endfunction

  // start of a new token
  always_comb begin
    b_mode = ssl_pkg::M_IDLE; b_emit = 1'b0; b_setpend = 1'b0; b_word = 1'b0;
    b_int = 1'b0;
    b_tk = mk(ssl_pkg::K_SINGLE, ssl_pkg::OP_NONE, {23'd0, c});
    if (c == 8'd0) begin
      b_emit = 1'b1; b_tk = mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0);
    end else if (is_blank) begin
      b_emit = 1'b0;
    end else if (c == "#") begin
      b_mode = ssl_pkg::M_COMMENT;
    end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "^" ||
                 c == "|" || c == "&" || c == "=" || c == "<" || c == ">" || c == "!") begin
      b_mode = ssl_pkg::M_OP1; b_setpend = 1'b1;
    end else if (c == "~") begin
      b_emit = 1'b1; b_tk = mk(ssl_pkg::K_BITNOT, ssl_pkg::OP_BNOT, '0);
    end else if (c == 8'd34) begin
      b_mode = ssl_pkg::M_STR;
    end else if (c == "$") begin
      b_mode = ssl_pkg::M_VAR; b_emit = 1'b1;
      b_tk = mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, {23'd0, c});
    end else if (is_dig) begin
      b_mode = ssl_pkg::M_INT; b_int = 1'b1;
    end else if (is_alp || c == "_") begin
      b_mode = ssl_pkg::M_WORD; b_word = 1'b1; b_emit = 1'b1;
      b_tk = mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, {23'd0, c});
    end else begin
      b_emit = 1'b1;
    end
  end

  // held operator against the next byte: 0 consumed, 1 not consumed, 2 second lookahead
  always_comb begin
    r_code = 2'd1;
    r_tk = mk(ssl_pkg::K_SINGLE, ssl_pkg::OP_NONE, {23'd0, pend_r});
    case (pend_r)
      "+": if (c == "+") begin r_code = 2'd0; r_tk = mk(ssl_pkg::K_INC, ssl_pkg::OP_INC, '0); end
           else if (c == "=") begin
             r_code = 2'd0; r_tk = mk(ssl_pkg::K_ASSIGN, ssl_pkg::OP_ADD, '0);
           end
      "-": if (c == ">") begin r_code = 2'd0; r_tk = mk(ssl_pkg::K_ARROW, ssl_pkg::OP_NONE, '0); end
           else if (c == "-") begin
             r_code = 2'd0; r_tk = mk(ssl_pkg::K_DEC, ssl_pkg::OP_DEC, '0);
           end else if (c == "=") begin
             r_code = 2'd0; r_tk = mk(ssl_pkg::K_ASSIGN, ssl_pkg::OP_SUB, '0);
           end
      "*", "/", "%", "^": begin
        r_tk.value = '0;
        r_tk.op = pend_r == "*" ? ssl_pkg::OP_MUL : pend_r == "/" ? ssl_pkg::OP_DIV :
                  pend_r == "%" ? ssl_pkg::OP_MOD : ssl_pkg::OP_XOR;
        if (c == "=") begin r_code = 2'd0; r_tk.kind = ssl_pkg::K_ASSIGN; end
        else r_tk.kind = ssl_pkg::K_MUL;
      end
      "|": if (c == "|") r_code = 2'd2;
           else r_tk = mk(ssl_pkg::K_BITOR, ssl_pkg::OP_BOR, '0);
      "&": if (c == "&") r_code = 2'd2;
           else r_tk = mk(ssl_pkg::K_BITAND, ssl_pkg::OP_BAND, '0);
      "=": if (c == "=") begin r_code = 2'd0; r_tk = mk(ssl_pkg::K_EQ, ssl_pkg::OP_NONE, '0); end
           else r_tk = mk(ssl_pkg::K_ASSIGN, ssl_pkg::OP_NONE, '0);
      "<": if (c == "<") begin r_code = 2'd0; r_tk = mk(ssl_pkg::K_SHIFT, ssl_pkg::OP_SHL, '0); end
           else if (c == "=") begin
             r_code = 2'd0; r_tk = mk(ssl_pkg::K_REL, ssl_pkg::OP_LE, '0);
           end else r_tk = mk(ssl_pkg::K_REL, ssl_pkg::OP_LT, '0);
      ">": if (c == ">") begin r_code = 2'd0; r_tk = mk(ssl_pkg::K_SHIFT, ssl_pkg::OP_SHR, '0); end
           else if (c == "=") begin
             r_code = 2'd0; r_tk = mk(ssl_pkg::K_REL, ssl_pkg::OP_GE, '0);
           end else r_tk = mk(ssl_pkg::K_REL, ssl_pkg::OP_GT, '0);
      "!": if (c == "=") begin r_code = 2'd0; r_tk = mk(ssl_pkg::K_EQ, ssl_pkg::OP_NE, '0); end
           else r_tk = mk(ssl_pkg::K_NOT, ssl_pkg::OP_NOT, '0);
      default: r_code = 2'd1;
    endcase
  end

  // keyword candidate filtering, both continuing a word and starting one
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      fed_cand[k] = cand_r[k] && wlen_r < ssl_pkg::kw_len(4'(k)) &&
                    ssl_pkg::kw_char(4'(k), wlen_r) == c;
      fresh_cand[k] = ssl_pkg::kw_char(4'(k), 4'd0) == c;
    end
    fed_len = (wlen_r < 4'd15) ? wlen_r + 4'd1 : wlen_r;
  end

  // word close: first exact-length candidate wins
  always_comb begin
    wc_tk = mk(ssl_pkg::K_WORD, ssl_pkg::OP_NONE, '0);
    for (int k = 15; k >= 0; k--) begin
      if (cand_r[k] && ssl_pkg::kw_len(4'(k)) == wlen_r) begin
        if (k < 14) wc_tk = mk(6'(ssl_pkg::K_KW0 + 6'(k)), ssl_pkg::OP_NONE, '0);
        else wc_tk = mk(ssl_pkg::K_BOOL, ssl_pkg::OP_NONE, {30'd0, k == 14});
      end
    end
  end

  assign acc10 = {acc_r, 3'b0} + {2'b0, acc_r, 1'b0} + {31'd0, dig};

  // main transition: a first token, then possibly begin() on the same byte
  always_comb begin
    logic do_begin;
    do_begin = 1'b0;
    mode_nxt = mode_r; pend_nxt = pend_r; cand_nxt = cand_r; wlen_nxt = wlen_r;
    acc_nxt = acc_r;
    n = 2'd0;
    tk[0] = b_tk; tk[1] = b_tk;
    unique case (mode_r)
      ssl_pkg::M_OP1: begin
        if (r_code == 2'd2) mode_nxt = ssl_pkg::M_OP2;
        else begin
          n = 2'd1; tk[0] = r_tk; mode_nxt = ssl_pkg::M_IDLE;
          do_begin = r_code == 2'd1;
        end
      end
      ssl_pkg::M_OP2: begin
        n = 2'd1; mode_nxt = ssl_pkg::M_IDLE;
        if (c == "=") tk[0] = mk(ssl_pkg::K_ASSIGN,
                                 pend_r == "|" ? ssl_pkg::OP_OR : ssl_pkg::OP_AND, '0);
        else begin
          tk[0] = pend_r == "|" ? mk(ssl_pkg::K_OROP, ssl_pkg::OP_OR, '0)
                                : mk(ssl_pkg::K_ANDOP, ssl_pkg::OP_AND, '0);
          do_begin = 1'b1;
        end
      end
      ssl_pkg::M_WORD: begin
        if (is_wch) begin
          cand_nxt = fed_cand; wlen_nxt = fed_len; n = 2'd1;
          tk[0] = mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, {23'd0, c});
        end else begin
          n = 2'd1; tk[0] = wc_tk; do_begin = 1'b1;
        end
      end
      ssl_pkg::M_VAR: begin
        n = 2'd1;
        if (is_wch) tk[0] = mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, {23'd0, c});
        else begin tk[0] = mk(ssl_pkg::K_VAR, ssl_pkg::OP_NONE, '0); do_begin = 1'b1; end
      end
      ssl_pkg::M_STR: begin
        n = 2'd1;
        if (c == 8'd34) begin
          tk[0] = mk(ssl_pkg::K_STRING, ssl_pkg::OP_NONE, '0); mode_nxt = ssl_pkg::M_IDLE;
        end else if (c == 8'd0) begin
          tk[0] = mk(ssl_pkg::K_ERR, ssl_pkg::OP_NONE, ssl_pkg::ERR_OPEN_STRING);
          do_begin = 1'b1;
        end else tk[0] = mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, {23'd0, c});
      end
      ssl_pkg::M_INT: begin
        if (is_dig) begin
          acc_nxt = (acc10 > {4'd0, ssl_pkg::INT_MAX31}) ? ssl_pkg::INT_MAX31 : acc10[30:0];
        end else if (is_alp) begin
          n = 2'd1; tk[0] = mk(ssl_pkg::K_ERR, ssl_pkg::OP_NONE, ssl_pkg::ERR_DIGIT_ALPHA);
          mode_nxt = ssl_pkg::M_DEAD;
        end else begin
          n = 2'd1; tk[0] = mk(ssl_pkg::K_INT, ssl_pkg::OP_NONE, acc_r); do_begin = 1'b1;
        end
      end
      ssl_pkg::M_COMMENT: begin
        if (c == 8'd0) do_begin = 1'b1;
        else if (c == 8'd13 || c == 8'd10 || c == 8'd255) mode_nxt = ssl_pkg::M_IDLE;
      end
      ssl_pkg::M_DEAD: if (c == 8'd0) do_begin = 1'b1;
      default: do_begin = 1'b1;
    endcase
    if (do_begin) begin
      mode_nxt = b_mode;
      if (b_setpend) pend_nxt = c;
      if (b_word) begin cand_nxt = fresh_cand; wlen_nxt = 4'd1; end
      if (b_int) acc_nxt = {27'd0, dig};
      if (b_emit) begin
        if (n == 2'd0) tk[0] = b_tk; else tk[1] = b_tk;
        n = n + 2'd1;
      end
    end
  end

  // queue entry with the last flag on the final token
  always_comb begin
    ent.two = n == 2'd2;
    ent.t0 = tk[0]; ent.t0.last = n == 2'd1;
    ent.t1 = tk[1]; ent.t1.last = 1'b1;
    ent_vld = fire && n != 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ssl_pkg::M_IDLE; pend_r <= '0; cand_r <= '1; wlen_r <= '0; acc_r <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt; pend_r <= pend_nxt; cand_r <= cand_nxt; wlen_r <= wlen_nxt;
      acc_r <= acc_nxt;
    end
  end
endmodule
`default_nettype wire

@@ src/ssl_back.sv @@
// Back end: entry queue and token serialiser onto the result channel
`default_nettype none
`include "script_source_lexer_assert.svh"
module ssl_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  ssl_pkg::entry_t  ent,
  output logic             full,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ssl_pkg::token_t  out_tok
);
  ssl_pkg::entry_t q_r [0:ssl_pkg::QDEPTH-1];
  logic [ssl_pkg::QAW-1:0] wp_r, rp_r;
  logic [ssl_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic half_r;
  logic pop_tok, pop_ent;
  ssl_pkg::entry_t head;

  assign head = q_r[rp_r];
  assign full = cnt_r == (ssl_pkg::QAW+1)'(ssl_pkg::QDEPTH);
  assign out_valid = cnt_r != '0;
  assign out_tok = half_r ? head.t1 : head.t0;
  assign pop_tok = out_valid && !out_stall;
  assign pop_ent = pop_tok && (half_r || !head.two);
  assign cnt_nxt = cnt_r + (ssl_pkg::QAW+1)'(push) - (ssl_pkg::QAW+1)'(pop_ent);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= ent;
  end

  // pointers and second-token flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; half_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop_ent) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
      if (pop_tok) half_r <= !pop_ent;
    end
  end

  `SSL_ASSERT_IMP(a_no_overflow, push, !full || pop_ent, "push into full queue")
  `SSL_ASSERT_IMP(a_half_two, half_r, head.two && out_valid, "second half without pair")
  `SSL_ASSERT_NXT(a_cnt_bound, 1'b1, cnt_r <= (ssl_pkg::QAW+1)'(ssl_pkg::QDEPTH),
                  "queue count out of range")
endmodule
`default_nettype wire

@@ bench/script_source_lexer_tb.sv @@
// Testbench for the byte-stream lexer: directed table and random source text
`timescale 1ns / 100ps
`default_nettype none
module script_source_lexer_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIRECTED_N = 25;

  typedef struct packed {
    logic [5:0]  kind;
    logic [4:0]  op;
    logic [30:0] value;
    logic        last;
  } lex_token_t;

  // one directed row: byte, flag for typed-in expectation, token count, expected first token
  typedef struct {
    logic [7:0] ch;
    bit         typed;
    int         n;
    lex_token_t tok;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_token_kind;
  logic [4:0]  out_op_code;
  logic [30:0] out_value;
  logic        out_last;

  script_source_lexer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char_code(in_char_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_op_code(out_op_code),
    .out_value(out_value), .out_last(out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  ssl_pkg::mode_t lx_mode;
  logic [7:0]  lx_held;
  logic [15:0] lx_cands;
  logic [3:0]  lx_len;
  logic [30:0] lx_acc;

  lex_token_t token_q[$];
  int         failures = 0;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         quiet_cycles = 0;
  stim_row_t  rows[DIRECTED_N];

  function automatic lex_token_t mk(logic [5:0] k, logic [4:0] o, logic [30:0] v);
    lex_token_t t;
    t.kind = k; t.op = o; t.value = v; t.last = 1'b0;
    return t;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_wch(logic [7:0] c);
    return is_alp(c) || is_dig(c) || c == "_" || c == ":";
  endfunction

  // own keyword table
  function automatic string kw_word(int k);
    string w[16] = '{"my", "our", "has", "sub", "package", "if", "elsif", "else",
                     "return", "for", "last", "continue", "use", "while", "true", "false"};
    return w[k];
  endfunction

  task automatic feed_letter(logic [7:0] c);
    string w;
    for (int k = 0; k < 16; k++) begin
      w = kw_word(k);
      if (lx_cands[k] && !(lx_len < w.len() && w[lx_len] == c)) lx_cands[k] = 1'b0;
    end
    if (lx_len < 15) lx_len++;
  endtask

  task automatic close_word(ref lex_token_t r[$]);
    string w;
    for (int k = 0; k < 16; k++) begin
      w = kw_word(k);
      if (lx_cands[k] && w.len() == lx_len) begin
        if (k < 14) r.push_back(mk(ssl_pkg::K_KW0 + 6'(k), ssl_pkg::OP_NONE, '0));
        else r.push_back(mk(ssl_pkg::K_BOOL, ssl_pkg::OP_NONE, (k == 14) ? 31'd1 : 31'd0));
        return;
      end
    end
    r.push_back(mk(ssl_pkg::K_WORD, ssl_pkg::OP_NONE, '0));
  endtask

  // start of a fresh token
  task automatic start_token(logic [7:0] c, ref lex_token_t r[$]);
    lx_mode = ssl_pkg::M_IDLE;
    if (c == 8'd0) r.push_back(mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    else if (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd255) ;
    else if (c == "#") lx_mode = ssl_pkg::M_COMMENT;
    else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "^" ||
             c == "|" || c == "&" || c == "=" || c == "<" || c == ">" || c == "!") begin
      lx_mode = ssl_pkg::M_OP1;
      lx_held = c;
    end else if (c == "~") r.push_back(mk(ssl_pkg::K_BITNOT, ssl_pkg::OP_BNOT, '0));
    else if (c == "\"") lx_mode = ssl_pkg::M_STR;
    else if (c == "$") begin
      lx_mode = ssl_pkg::M_VAR;
      r.push_back(mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, 31'(c)));
    end else if (is_dig(c)) begin
      lx_mode = ssl_pkg::M_INT;
      lx_acc = 31'(c - "0");
    end else if (is_alp(c) || c == "_") begin
      lx_mode = ssl_pkg::M_WORD;
      lx_len = '0;
      lx_cands = 16'hFFFF;
      feed_letter(c);
      r.push_back(mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, 31'(c)));
    end else r.push_back(mk(ssl_pkg::K_SINGLE, ssl_pkg::OP_NONE, 31'(c)));
  endtask

  // held operator against the next byte: 0 consumed, 1 relex, 2 second lookahead
  function automatic int resolve_op(logic [7:0] p, logic [7:0] c, output lex_token_t t);
    t = mk(ssl_pkg::K_SINGLE, ssl_pkg::OP_NONE, 31'(p));
    case (p)
      "+": begin
        if (c == "+") begin t = mk(ssl_pkg::K_INC, ssl_pkg::OP_INC, '0); return 0; end
        if (c == "=") begin t = mk(ssl_pkg::K_ASSIGN, ssl_pkg::OP_ADD, '0); return 0; end
        return 1;
      end
      "-": begin
        if (c == ">") begin t = mk(ssl_pkg::K_ARROW, ssl_pkg::OP_NONE, '0); return 0; end
        if (c == "-") begin t = mk(ssl_pkg::K_DEC, ssl_pkg::OP_DEC, '0); return 0; end
        if (c == "=") begin t = mk(ssl_pkg::K_ASSIGN, ssl_pkg::OP_SUB, '0); return 0; end
        return 1;
      end
      "*", "/", "%", "^": begin
        logic [4:0] o;
        o = (p == "*") ? ssl_pkg::OP_MUL : (p == "/") ? ssl_pkg::OP_DIV :
            (p == "%") ? ssl_pkg::OP_MOD : ssl_pkg::OP_XOR;
        if (c == "=") begin t = mk(ssl_pkg::K_ASSIGN, o, '0); return 0; end
        t = mk(ssl_pkg::K_MUL, o, '0);
        return 1;
      end
      "|": begin
        if (c == "|") return 2;
        t = mk(ssl_pkg::K_BITOR, ssl_pkg::OP_BOR, '0);
        return 1;
      end
      "&": begin
        if (c == "&") return 2;
        t = mk(ssl_pkg::K_BITAND, ssl_pkg::OP_BAND, '0);
        return 1;
      end
      "=": begin
        if (c == "=") begin t = mk(ssl_pkg::K_EQ, ssl_pkg::OP_NONE, '0); return 0; end
        t = mk(ssl_pkg::K_ASSIGN, ssl_pkg::OP_NONE, '0);
        return 1;
      end
      "<": begin
        if (c == "<") begin t = mk(ssl_pkg::K_SHIFT, ssl_pkg::OP_SHL, '0); return 0; end
        if (c == "=") begin t = mk(ssl_pkg::K_REL, ssl_pkg::OP_LE, '0); return 0; end
        t = mk(ssl_pkg::K_REL, ssl_pkg::OP_LT, '0);
        return 1;
      end
      ">": begin
        if (c == ">") begin t = mk(ssl_pkg::K_SHIFT, ssl_pkg::OP_SHR, '0); return 0; end
        if (c == "=") begin t = mk(ssl_pkg::K_REL, ssl_pkg::OP_GE, '0); return 0; end
        t = mk(ssl_pkg::K_REL, ssl_pkg::OP_GT, '0);
        return 1;
      end
      "!": begin
        if (c == "=") begin t = mk(ssl_pkg::K_EQ, ssl_pkg::OP_NE, '0); return 0; end
        t = mk(ssl_pkg::K_NOT, ssl_pkg::OP_NOT, '0);
        return 1;
      end
      default: return 1;
    endcase
  endfunction

  // predict the tokens caused by one byte
  task automatic lex_byte(logic [7:0] c, ref lex_token_t r[$]);
    lex_token_t t;
    int rc;
    logic [4:0] o;
    logic [31:0] d;
    r.delete();
    case (lx_mode)
      ssl_pkg::M_OP1: begin
        rc = resolve_op(lx_held, c, t);
        if (rc == 2) lx_mode = ssl_pkg::M_OP2;
        else begin
          r.push_back(t);
          lx_mode = ssl_pkg::M_IDLE;
          if (rc == 1) start_token(c, r);
        end
      end
      ssl_pkg::M_OP2: begin
        o = (lx_held == "|") ? ssl_pkg::OP_OR : ssl_pkg::OP_AND;
        lx_mode = ssl_pkg::M_IDLE;
        if (c == "=") r.push_back(mk(ssl_pkg::K_ASSIGN, o, '0));
        else begin
          r.push_back(mk((o == ssl_pkg::OP_OR) ? ssl_pkg::K_OROP : ssl_pkg::K_ANDOP, o, '0));
          start_token(c, r);
        end
      end
      ssl_pkg::M_WORD: begin
        if (is_wch(c)) begin
          feed_letter(c);
          r.push_back(mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, 31'(c)));
        end else begin
          close_word(r);
          start_token(c, r);
        end
      end
      ssl_pkg::M_VAR: begin
        if (is_wch(c)) r.push_back(mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, 31'(c)));
        else begin
          r.push_back(mk(ssl_pkg::K_VAR, ssl_pkg::OP_NONE, '0));
          start_token(c, r);
        end
      end
      ssl_pkg::M_STR: begin
        if (c == "\"") begin
          r.push_back(mk(ssl_pkg::K_STRING, ssl_pkg::OP_NONE, '0));
          lx_mode = ssl_pkg::M_IDLE;
        end else if (c == 8'd0) begin
          r.push_back(mk(ssl_pkg::K_ERR, ssl_pkg::OP_NONE, ssl_pkg::ERR_OPEN_STRING));
          start_token(c, r);
        end else r.push_back(mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, 31'(c)));
      end
      ssl_pkg::M_INT: begin
        if (is_dig(c)) begin
          d = 32'(c - "0");
          if (32'(lx_acc) > (32'(ssl_pkg::INT_MAX31) - d) / 10) lx_acc = ssl_pkg::INT_MAX31;
          else lx_acc = 31'(32'(lx_acc) * 10 + d);
        end else if (is_alp(c)) begin
          r.push_back(mk(ssl_pkg::K_ERR, ssl_pkg::OP_NONE, ssl_pkg::ERR_DIGIT_ALPHA));
          lx_mode = ssl_pkg::M_DEAD;
        end else begin
          r.push_back(mk(ssl_pkg::K_INT, ssl_pkg::OP_NONE, lx_acc));
          start_token(c, r);
        end
      end
      ssl_pkg::M_COMMENT: begin
        if (c == 8'd0) start_token(c, r);
        else if (c == 8'd13 || c == 8'd10 || c == 8'd255) lx_mode = ssl_pkg::M_IDLE;
      end
      ssl_pkg::M_DEAD: if (c == 8'd0) start_token(c, r);
      default: start_token(c, r);
    endcase
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
  endtask

  // random source fragment, mostly well-formed
  function automatic string rand_fragment();
    string s;
    int n;
    string ops[26] = '{"++", "--", "+=", "-=", "->", "*", "/=", "%", "^=", "||", "||=",
                       "&&", "&&=", "|", "&", "==", "!=", "=", "<", "<=", "<<", ">",
                       ">=", ">>", "!", "~"};
    s = "";
    case ($urandom_range(0, 11))
      0: s = kw_word($urandom_range(0, 15));
      1: begin
        s = kw_word($urandom_range(0, 15));
        n = $urandom_range(0, 2);
        if (n == 0) s = s.substr(0, s.len() - 2);
        else if (n == 1) s = {s, "x"};
      end
      2: begin
        s = "$";
        n = $urandom_range(0, 5);
        repeat (n) s = {s, string'(8'($urandom_range(97, 122)))};
        if ($urandom_range(0, 1)) s = {s, "::_9"};
      end
      3: begin
        s = "\"";
        n = $urandom_range(0, 4);
        repeat (n) s = {s, string'(8'($urandom_range(1, 255)))};
        s = {s, "\""};
      end
      4: begin
        n = $urandom_range(1, 12);
        repeat (n) s = {s, string'(8'($urandom_range(48, 57)))};
      end
      5: s = ops[$urandom_range(0, 25)];
      6: s = {"# ", string'(8'($urandom_range(33, 126))), "\n"};
      7: s = {string'(8'($urandom_range(48, 57))), string'(8'($urandom_range(97, 122)))};
      8: begin
        n = $urandom_range(1, 6);
        repeat (n) s = {s, string'(8'($urandom_range(95, 122)))};
      end
      9: s = " ";
      10: s = {"\"", string'(8'($urandom_range(32, 126)))};
      default: s = string'(8'($urandom_range(1, 255)));
    endcase
    return s;
  endfunction

  // send one byte and record its predicted tokens
  task automatic send_byte(logic [7:0] c);
    lex_token_t r[$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_byte(c, r);
    foreach (r[i]) token_q.push_back(r[i]);
  endtask

  task automatic set_row(int i, logic [7:0] c, bit typed, int n, lex_token_t t);
    rows[i].ch = c; rows[i].typed = typed; rows[i].n = n; rows[i].tok = t;
  endtask

  // result side: stall and compare
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        quiet_cycles <= 0;
        if (token_q.size() == 0) begin
          $error("unexpected token kind %0d", out_token_kind);
          failures++;
        end else begin
          if (out_token_kind !== token_q[0].kind) begin
            $error("token_kind exp %0d got %0d", token_q[0].kind, out_token_kind);
            failures++;
          end
          if (out_op_code !== token_q[0].op) begin
            $error("op_code exp %0d got %0d", token_q[0].op, out_op_code);
            failures++;
          end
          if (out_value !== token_q[0].value) begin
            $error("value exp %0d got %0d", token_q[0].value, out_value);
            failures++;
          end
          if (out_last !== token_q[0].last) begin
            $error("last exp %0d got %0d", token_q[0].last, out_last);
            failures++;
          end
          void'(token_q.pop_front());
        end
      end else if (in_valid && !in_stall) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("script_source_lexer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    string s;
    int remaining;
    bit add_end;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = 8'd0;
    out_stall = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 87;
    lx_mode = ssl_pkg::M_IDLE; lx_held = '0; lx_cands = 16'hFFFF; lx_len = '0; lx_acc = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: end after reset, extremes, saturation, errors, the != operator
    set_row(0, 8'd0, 1, 1, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    set_row(1, 8'd255, 1, 0, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    set_row(2, 8'd254, 1, 1, mk(ssl_pkg::K_SINGLE, ssl_pkg::OP_NONE, 31'd254));
    set_row(3, 8'd1, 1, 1, mk(ssl_pkg::K_SINGLE, ssl_pkg::OP_NONE, 31'd1));
    set_row(4, "~", 1, 1, mk(ssl_pkg::K_BITNOT, ssl_pkg::OP_BNOT, '0));
    set_row(5, "9", 0, 0, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    for (int i = 6; i < 15; i++) set_row(i, "9", 0, 0, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    set_row(15, " ", 1, 1, mk(ssl_pkg::K_INT, ssl_pkg::OP_NONE, ssl_pkg::INT_MAX31));
    set_row(16, "7", 0, 0, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    set_row(17, "q", 1, 1, mk(ssl_pkg::K_ERR, ssl_pkg::OP_NONE, ssl_pkg::ERR_DIGIT_ALPHA));
    set_row(18, "\"", 0, 0, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    set_row(19, 8'd0, 1, 1, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    set_row(20, "\"", 0, 0, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    set_row(21, 8'd255, 1, 1, mk(ssl_pkg::K_TEXT, ssl_pkg::OP_NONE, 31'd255));
    set_row(22, 8'd0, 1, 2, mk(ssl_pkg::K_ERR, ssl_pkg::OP_NONE, ssl_pkg::ERR_OPEN_STRING));
    set_row(23, "!", 0, 0, mk(ssl_pkg::K_END, ssl_pkg::OP_NONE, '0));
    set_row(24, "=", 1, 1, mk(ssl_pkg::K_EQ, ssl_pkg::OP_NE, '0));
    foreach (rows[i]) begin
      lx_mode = lx_mode;
      send_byte(rows[i].ch);
      if (rows[i].typed && rows[i].n > 0) begin
        if (token_q[token_q.size() - rows[i].n] !== {rows[i].tok[42:1],
            (rows[i].n == 1) ? 1'b1 : 1'b0}) begin
          $error("token exp %h got %h", rows[i].tok, token_q[token_q.size() - rows[i].n]);
          failures++;
        end
      end
    end
    // keywords through the predictor
    for (int k = 0; k < 16; k++) begin
      s = {kw_word(k), " "};
      for (int j = 0; j < s.len(); j++) send_byte(s[j]);
    end

    // random phases with changing idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 87 : 0;
      recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 30 : 0;
      remaining = 280;
      while (remaining > 0) begin
        s = rand_fragment();
        add_end = 1'b0;
        if ($urandom_range(0, 30) == 0) add_end = 1'b1;
        else if ($urandom_range(0, 3) != 0) s = {s, " "};
        for (int j = 0; j < s.len() && remaining > 0; j++) begin
          send_byte(s[j]);
          remaining--;
        end
        if (add_end && remaining > 0) begin
          send_byte(8'd0);
          remaining--;
        end
      end
      send_byte(8'd0);
    end
    in_valid <= 1'b0;

    // drain
    while (token_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) $display("script_source_lexer_tb OK");
    else $display("script_source_lexer_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
